@@ hdl/elt_pkg.sv @@
// ----------------------------------------------------------------------------
// elt_pkg
// Shared types, codes and helpers for the exec line tokenizer.
// ----------------------------------------------------------------------------
package elt_pkg;

    // result kinds carried on the output tuser
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_ARG_END  = 2'd1;
    localparam logic [1:0] KIND_LINE_END = 2'd2;

    // special code units
    localparam logic [15:0] CH_PERCENT   = 16'h0025;
    localparam logic [15:0] CH_QUOTE     = 16'h0022;
    localparam logic [15:0] CH_BACKSLASH = 16'h005C;

    localparam int CHAR_W = 16;
    localparam int KIND_W = 2;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // results caused by one input character, emitted in field order
    typedef struct packed {
        logic              has_char;
        logic [CHAR_W-1:0] char_val;
        logic              has_arg_end;
        logic              has_line_end;
    } t_op;

    // splitter and field code state
    typedef struct packed {
        logic in_quotes;
        logic escape_pending;
        logic have_arg;
        logic raw_nonempty;
        logic percent_pending;
        logic cleaned_nonempty;
    } t_fstate;

    // unicode bmp whitespace set
    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        logic r;
        r = (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D) ||
            (c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680) ||
            (c >= 16'h2000 && c <= 16'h200A) ||
            (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
            (c == 16'h205F) || (c == 16'h3000);
        return r;
    endfunction

endpackage

@@ hdl/elt_front.sv @@
// ----------------------------------------------------------------------------
// elt_front
// Classifies each incoming character, tracks quoting and field code state,
// and produces at most one result record per character for the queue.
// ----------------------------------------------------------------------------
module elt_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [elt_pkg::CHAR_W-1:0] i_ch,
    input  logic                     i_last,
    output logic                     o_push,
    output elt_pkg::t_op             o_op,
    output elt_pkg::t_fstate         o_state
);

    elt_pkg::t_fstate r_st;
    elt_pkg::t_fstate n_st;
    elt_pkg::t_op     op;
    logic             do_raw;
    logic             do_close;

    // per character decode and state update
    always_comb begin
        n_st     = r_st;
        op       = '0;
        do_raw   = 1'b0;
        do_close = 1'b0;

        // splitting
        if (r_st.in_quotes) begin
            if (r_st.escape_pending) begin
                n_st.escape_pending = 1'b0;
                do_raw = 1'b1;
            end else if (i_ch == elt_pkg::CH_BACKSLASH) begin
                if (i_last) begin
                    do_raw = 1'b1;
                end else begin
                    n_st.escape_pending = 1'b1;
                end
            end else if (i_ch == elt_pkg::CH_QUOTE) begin
                n_st.in_quotes = 1'b0;
            end else begin
                do_raw = 1'b1;
            end
        end else if (i_ch == elt_pkg::CH_QUOTE) begin
            n_st.in_quotes = 1'b1;
            n_st.have_arg  = 1'b1;
        end else if (elt_pkg::is_space(i_ch)) begin
            do_close = r_st.have_arg;
        end else begin
            do_raw = 1'b1;
        end

        // field code removal on an argument unit
        if (do_raw) begin
            n_st.have_arg     = 1'b1;
            n_st.raw_nonempty = 1'b1;
            if (r_st.percent_pending) begin
                n_st.percent_pending = 1'b0;
                if (i_ch == elt_pkg::CH_PERCENT) begin
                    op.has_char = 1'b1;
                    op.char_val = elt_pkg::CH_PERCENT;
                    n_st.cleaned_nonempty = 1'b1;
                end
            end else if (i_ch == elt_pkg::CH_PERCENT) begin
                n_st.percent_pending = 1'b1;
            end else begin
                op.has_char = 1'b1;
                op.char_val = i_ch;
                n_st.cleaned_nonempty = 1'b1;
            end
        end

        // argument close on whitespace or at end of line
        if (do_close || (i_last && n_st.have_arg)) begin
            if (n_st.percent_pending) begin
                op.has_char = 1'b1;
                op.char_val = elt_pkg::CH_PERCENT;
                n_st.cleaned_nonempty = 1'b1;
            end
            op.has_arg_end = n_st.cleaned_nonempty || !n_st.raw_nonempty;
            n_st.have_arg         = 1'b0;
            n_st.raw_nonempty     = 1'b0;
            n_st.percent_pending  = 1'b0;
            n_st.cleaned_nonempty = 1'b0;
        end

        // end of line restarts everything
        if (i_last) begin
            op.has_line_end = 1'b1;
            n_st = '0;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

    assign o_push  = i_accept && (op.has_char || op.has_arg_end || op.has_line_end);
    assign o_op    = op;
    assign o_state = r_st;

endmodule

@@ hdl/elt_queue.sv @@
// ----------------------------------------------------------------------------
// elt_queue
// Small fifo of result records between the front and the back.
// ----------------------------------------------------------------------------
module elt_queue #(
    parameter int DEPTH = elt_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  elt_pkg::t_op                i_op,
    input  logic                        i_pop,
    output elt_pkg::t_op                o_op,
    output logic                        o_empty,
    output logic                        o_full,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    elt_pkg::t_op       r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_op    = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_count = r_cnt;

endmodule

@@ hdl/elt_back.sv @@
// ----------------------------------------------------------------------------
// elt_back
// Expands each result record into output beats: character, end of
// argument, end of line, in that order.
// ----------------------------------------------------------------------------
module elt_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  elt_pkg::t_op               i_op,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [elt_pkg::CHAR_W-1:0] o_tdata,
    output logic [elt_pkg::KIND_W-1:0] o_tuser
);

    elt_pkg::t_op r_cur;
    elt_pkg::t_op n_cur;
    elt_pkg::t_op rest;
    logic         beat;
    logic         rest_any;

    assign o_tvalid = r_cur.has_char || r_cur.has_arg_end || r_cur.has_line_end;
    assign beat     = o_tvalid && i_tready;

    // drop the beat being sent, keep the rest
    always_comb begin
        rest = r_cur;
        if (r_cur.has_char) begin
            rest.has_char = 1'b0;
        end else if (r_cur.has_arg_end) begin
            rest.has_arg_end = 1'b0;
        end else begin
            rest.has_line_end = 1'b0;
        end
    end

    assign rest_any = rest.has_char || rest.has_arg_end || rest.has_line_end;
    assign o_pop    = !i_empty && (!o_tvalid || (beat && !rest_any));

    // next record
    always_comb begin
        if (o_pop) begin
            n_cur = i_op;
        end else if (beat) begin
            n_cur = rest;
        end else begin
            n_cur = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else begin
            r_cur <= n_cur;
        end
    end

    // beat payload
    always_comb begin
        if (r_cur.has_char) begin
            o_tuser = elt_pkg::KIND_CHAR;
            o_tdata = r_cur.char_val;
        end else if (r_cur.has_arg_end) begin
            o_tuser = elt_pkg::KIND_ARG_END;
            o_tdata = '0;
        end else begin
            o_tuser = elt_pkg::KIND_LINE_END;
            o_tdata = '0;
        end
    end

endmodule

@@ hdl/exec_line_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// exec_line_tokenizer_core
// Splits a command line into arguments and strips field codes.
// ----------------------------------------------------------------------------
// Input stream: one UTF-16 code unit per beat on s_axis_tdata, s_axis_tlast
// on the final unit of a line. Output stream: one result per beat,
// m_axis_tuser gives the kind (argument character, end of argument, end of
// line) and m_axis_tdata the character, zero for markers.
// The front decodes one character per cycle while the fifo has room and
// writes at most one record into a QUEUE_DEPTH deep fifo; the back turns a
// record into one to three beats, first registering it from the fifo into
// its output register. Throughput is one input beat per cycle while the
// receiver is ready and each character yields at most one beat; boundary
// beats are absorbed by the fifo. Characters that yield nothing (quotes,
// escapes, separators) are accepted but write no record.
// When the receiver stalls, the current beat holds and the fifo fills;
// s_axis_tready falls once it is full. Synchronous reset clears the
// tokenizer state, the fifo and the output stage; the next beat starts a
// new line.
// ----------------------------------------------------------------------------
module exec_line_tokenizer_core #(
    parameter int QUEUE_DEPTH = elt_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] ch
    input  logic        s_axis_tlast,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_char
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic             accept;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    logic [CNT_W-1:0] q_count;
    elt_pkg::t_op     f_op;
    elt_pkg::t_op     q_op;
    elt_pkg::t_fstate f_state;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // character decode
    elt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_op     (f_op),
        .o_state  (f_state)
    );

    // record queue
    elt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (f_op),
        .i_pop   (pop),
        .o_op    (q_op),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    // beat expansion
    elt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (q_op),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

    // markers carry no character
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != elt_pkg::KIND_CHAR |-> m_axis_tdata == '0)
        else $error("marker beat with nonzero character");

    // an escape only exists inside quotes
    a_escape_quoted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_state.escape_pending |-> f_state.in_quotes)
        else $error("escape pending outside quotes");

    // a pending percent belongs to an open argument
    a_percent_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_state.percent_pending |-> f_state.have_arg && f_state.raw_nonempty)
        else $error("percent pending without argument");

    // end of line leaves the tokenizer idle
    a_line_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tlast |=> f_state == '0)
        else $error("state not cleared after end of line");

    // fifo never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
